FILE: hdl/qi_pkg.sv
// Package for the three-point quadratic interpolator.
// Holds word types, status codes and datapath widths; depends on nothing.
`default_nettype none
package qi_pkg;

	localparam logic [31:0] NAN_CODE = 32'h8000_0000;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_XNAN = 3'd1;
	localparam logic [2:0] ST_TNAN = 3'd2;
	localparam logic [2:0] ST_EQ   = 3'd3;
	localparam logic [2:0] ST_SAT  = 3'd4;

	// Widths of the wide datapath
	localparam int MUL_W = 67;
	localparam int NUM_W = 135;
	localparam int DEN_W = 100;
	localparam int QUO_W = 41;
	localparam int CMP_W = 142;

	typedef struct packed {
		logic signed [31:0] query_t;
		logic signed [31:0] x_a;
		logic signed [31:0] x_b;
		logic signed [31:0] x_c;
		logic signed [31:0] y_a;
		logic signed [31:0] y_b;
		logic signed [31:0] y_c;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} out_word_t;

	// Side info that rides along the pipeline
	typedef struct packed {
		logic               is_spec;
		logic [2:0]         status;
		logic signed [31:0] sval;
		logic signed [31:0] y0;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
		logic             ovf;
		logic             neg;
		side_t            side;
	} div_t;

endpackage
`default_nettype wire

FILE: hdl/qi_mul.sv
// Two-stage signed multiplier built from four partial products.
// Depends on qi_pkg for the default width.
`default_nettype none
module qi_mul
	import qi_pkg::*;
#(
	parameter int AW = MUL_W
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [AW-1:0]   a,
	input  wire logic signed [AW-1:0]   b,
	output logic signed [2*AW-1:0]      p
);

	localparam int LW = AW / 2;
	localparam int HW = AW - LW;

	logic signed [LW:0]   al, bl;
	logic signed [HW-1:0] ah, bh;

	logic signed [2*LW+1:0]   ll_s1;
	logic signed [LW+HW:0]    lh_s1, hl_s1;
	logic signed [2*HW-1:0]   hh_s1;

	assign al = $signed({1'b0, a[LW-1:0]});
	assign bl = $signed({1'b0, b[LW-1:0]});
	assign ah = a[AW-1:LW];
	assign bh = b[AW-1:LW];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= al * bl;
			lh_s1 <= al * bh;
			hl_s1 <= ah * bl;
			hh_s1 <= ah * bh;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= ((2*AW)'(hh_s1) <<< (2*LW)) + ((2*AW)'(lh_s1) <<< LW)
				+ ((2*AW)'(hl_s1) <<< LW) + (2*AW)'(ll_s1);
		end
	end

endmodule
`default_nettype wire

FILE: hdl/qi_div_cell.sv
// One cell of the restoring divider row: settles quotient bit K.
// Depends on qi_pkg for div_t.
`default_nettype none
module qi_div_cell
	import qi_pkg::*;
#(
	parameter int K = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_vld,
	input  wire div_t in_d,
	output logic      out_vld,
	output div_t      out_d
);

	logic [CMP_W-1:0] rem_w, dsh_w;
	logic             take;
	div_t             nxt;

	always_comb begin
		rem_w = CMP_W'(in_d.rem);
		dsh_w = CMP_W'(in_d.den) << K;
		take  = !in_d.ovf && (rem_w >= dsh_w);
		nxt   = in_d;
		if (take) begin
			nxt.rem    = NUM_W'(rem_w - dsh_w);
			nxt.quo[K] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/quadratic_interp_3pt.sv
// Top level of the three-point quadratic interpolator (Newton form, Q16.16).
// Depends on qi_pkg, qi_mul and qi_div_cell.
//
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  input     | in_valid, in_ready, in_word      | in
//  result    | out_valid, out_ready, out_word   | out
//  config    | cfg_we, cfg_wdata                | in
//
// One word enters per cycle while the pipeline advances; each passes through nine
// arithmetic stages, the row of 41 divider cells (one quotient bit per cell),
// a rounding stage and the output register.
// The whole pipeline advances together; it freezes only while a result
// waits in the output register and out_ready is low.
// Reset clears the valid bits and the NaN-query register; data regs need none.
`default_nettype none
module quadratic_interp_3pt
	import qi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_word_t    in_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_word_t        out_word
);

	logic        adv;
	logic [31:0] nan_q;
	logic [9:1]  vld;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nan_q <= '0;
		end else if (cfg_we) begin
			nan_q <= cfg_wdata;
		end
	end

	// Advance the whole row unless a result is held
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[8:1], in_valid};
		end
	end

	// Stage 1: classify, pick the Newton base end
	logic               swap, xnan, tnan, eqx;
	logic signed [31:0] x0, xf, y0, yf;
	side_t              side_d;
	logic signed [31:0] t_s1, x0_s1, x1_s1, xf_s1, y0_s1, y1_s1, yf_s1;
	side_t              side_s1;

	always_comb begin
		xnan = (in_word.x_a == NAN_CODE) || (in_word.x_b == NAN_CODE)
			|| (in_word.x_c == NAN_CODE);
		tnan = (in_word.query_t == NAN_CODE);
		swap = in_word.x_b < in_word.x_a;
		x0   = swap ? in_word.x_c : in_word.x_a;
		y0   = swap ? in_word.y_c : in_word.y_a;
		xf   = swap ? in_word.x_a : in_word.x_c;
		yf   = swap ? in_word.y_a : in_word.y_c;
		eqx  = (in_word.x_b == x0) || (xf == in_word.x_b) || (xf == x0);
		side_d.y0 = y0;
		side_d.is_spec = 1'b1;
		side_d.sval = '0;
		if (xnan) begin
			side_d.status = ST_XNAN;
		end else if (tnan) begin
			side_d.status = ST_TNAN;
			side_d.sval   = nan_q;
		end else if (eqx) begin
			side_d.status = ST_EQ;
		end else begin
			side_d.status  = ST_OK;
			side_d.is_spec = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= in_word.query_t;
			x0_s1   <= x0;
			x1_s1   <= in_word.x_b;
			xf_s1   <= xf;
			y0_s1   <= y0;
			y1_s1   <= in_word.y_b;
			yf_s1   <= yf;
			side_s1 <= side_d;
		end
	end

	// Stage 2: differences
	logic signed [32:0] tx0_s2, tx1_s2, dya_s2, dyb_s2, d1_s2, d2_s2, d3_s2;
	side_t              side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			tx0_s2  <= 33'(t_s1) - 33'(x0_s1);
			tx1_s2  <= 33'(t_s1) - 33'(x1_s1);
			dya_s2  <= 33'(y1_s1) - 33'(y0_s1);
			dyb_s2  <= 33'(yf_s1) - 33'(y1_s1);
			d1_s2   <= 33'(x1_s1) - 33'(x0_s1);
			d2_s2   <= 33'(xf_s1) - 33'(x1_s1);
			d3_s2   <= 33'(xf_s1) - 33'(x0_s1);
			side_s2 <= side_s1;
		end
	end

	// Stage 3: first-level products
	logic signed [65:0] a_s3, b_s3, c_s3, e_s3, f_s3;
	logic signed [32:0] d1_s3;
	side_t              side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3    <= tx0_s2 * dya_s2;
			b_s3    <= d2_s2 * d3_s2;
			c_s3    <= tx0_s2 * tx1_s2;
			e_s3    <= dyb_s2 * d1_s2;
			f_s3    <= dya_s2 * d2_s2;
			d1_s3   <= d1_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: second divided-difference numerator
	logic signed [MUL_W-1:0] a_s4, b_s4, c_s4, g_s4, d1_s4;
	side_t                   side_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4    <= MUL_W'(a_s3);
			b_s4    <= MUL_W'(b_s3);
			c_s4    <= MUL_W'(c_s3);
			g_s4    <= MUL_W'(e_s3) - MUL_W'(f_s3);
			d1_s4   <= MUL_W'(d1_s3);
			side_s4 <= side_s3;
		end
	end

	// Stages 5-6: wide products
	logic signed [2*MUL_W-1:0] p_s6, q_s6, den_s6;
	side_t                     side_s5, side_s6;

	qi_mul #(.AW(MUL_W)) u_mul_p (.clk(clk), .en(adv), .a(a_s4), .b(b_s4), .p(p_s6));
	qi_mul #(.AW(MUL_W)) u_mul_q (.clk(clk), .en(adv), .a(c_s4), .b(g_s4), .p(q_s6));
	qi_mul #(.AW(MUL_W)) u_mul_d (.clk(clk), .en(adv), .a(d1_s4), .b(b_s4), .p(den_s6));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			side_s6 <= side_s5;
		end
	end

	// Stage 7: numerator over the common denominator
	logic signed [NUM_W-1:0]   num_s7;
	logic signed [2*MUL_W-1:0] den_s7;
	side_t                     side_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s7  <= NUM_W'(p_s6) + NUM_W'(q_s6);
			den_s7  <= den_s6;
			side_s7 <= side_s6;
		end
	end

	// Stage 8: magnitudes and quotient sign
	logic [NUM_W-1:0] anum_s8;
	logic [DEN_W-1:0] aden_s8;
	logic             neg_s8;
	side_t            side_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			anum_s8 <= num_s7[NUM_W-1] ? NUM_W'(-num_s7) : NUM_W'(num_s7);
			aden_s8 <= den_s7[2*MUL_W-1] ? DEN_W'(-den_s7) : DEN_W'(den_s7);
			neg_s8  <= num_s7[NUM_W-1] ^ den_s7[2*MUL_W-1];
			side_s8 <= side_s7;
		end
	end

	// Stage 9: flag quotients too large for the cell row
	div_t div_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s9.rem  <= anum_s8;
			div_s9.den  <= aden_s8;
			div_s9.quo  <= '0;
			div_s9.neg  <= neg_s8;
			div_s9.side <= side_s8;
			div_s9.ovf  <= CMP_W'(anum_s8) >= (CMP_W'(aden_s8) << QUO_W);
		end
	end

	// Divider row: cell i settles quotient bit QUO_W-1-i, high bits first
	div_t             cd [QUO_W+1];
	logic [QUO_W:0]   cv;

	assign cd[0] = div_s9;
	assign cv[0] = vld[9];

	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		qi_div_cell #(.K(QUO_W-1-i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.in_vld (cv[i]),
			.in_d   (cd[i]),
			.out_vld(cv[i+1]),
			.out_d  (cd[i+1])
		);
	end

	// Rounding stage: round to nearest, ties away from zero
	div_t             dl;
	logic [QUO_W:0]   qr_r;
	logic             big_r, neg_r, vld_r;
	side_t            side_r;
	logic [QUO_W:0]   qr;

	assign dl = cd[QUO_W];
	assign qr = (QUO_W+1)'(dl.quo)
		+ (QUO_W+1)'((CMP_W'(dl.rem) << 1) >= CMP_W'(dl.den));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r <= 1'b0;
		end else if (adv) begin
			vld_r <= cv[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qr_r   <= qr;
			big_r  <= dl.ovf || (qr[QUO_W:QUO_W-1] != 2'b00);
			neg_r  <= dl.neg;
			side_r <= dl.side;
		end
	end

	// Output stage: add base ordinate, saturate, apply special cases
	logic signed [QUO_W+1:0] sum;
	out_word_t               res;

	always_comb begin
		if (big_r) begin
			sum = neg_r ? -(QUO_W+2)'(64'sh1_0000_0000) : (QUO_W+2)'(64'sh1_0000_0000);
		end else if (neg_r) begin
			sum = (QUO_W+2)'(side_r.y0) - $signed({1'b0, qr_r});
		end else begin
			sum = (QUO_W+2)'(side_r.y0) + $signed({1'b0, qr_r});
		end
		res.status = ST_OK;
		res.value  = sum[31:0];
		if (sum > (QUO_W+2)'(64'sh7FFF_FFFF)) begin
			res.value  = 32'sh7FFF_FFFF;
			res.status = ST_SAT;
		end else if (sum < -(QUO_W+2)'(64'sh7FFF_FFFF)) begin
			res.value  = 32'sh8000_0001;
			res.status = ST_SAT;
		end
		if (side_r.is_spec) begin
			res.value  = side_r.sval;
			res.status = side_r.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_r;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word <= res;
		end
	end

endmodule
`default_nettype wire
